// File: rtl/lfu_pkg.sv
// Shared types and constants for the LFU cache table.
`default_nettype none

package lfu_pkg;

    localparam int CAPACITY_DEF   = 16;
    localparam int KEY_BITS_DEF   = 32;
    localparam int VALUE_BITS_DEF = 32;
    localparam int COUNT_BITS_DEF = 16;

    localparam int PORT_KEY_W   = 32;
    localparam int PORT_VALUE_W = 32;
    localparam int CAP_W        = 5;

    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    localparam logic OP_GET = 1'b0;
    localparam logic OP_PUT = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_UPDATE,
        ST_RESP
    } state_t;

endpackage

`default_nettype wire

// File: rtl/lfu_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module lfu_ram #(
    parameter int WIDTH     = 80,
    parameter int DEPTH     = 16,
    parameter int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic                 clk,
    input  wire logic                 we,
    input  wire logic [ADDR_BITS-1:0] waddr,
    input  wire logic [WIDTH-1:0]     wdata,
    input  wire logic                 re,
    input  wire logic [ADDR_BITS-1:0] raddr,
    output logic      [WIDTH-1:0]     rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// File: rtl/lfu_cache_table.sv
// Top level: fully associative LFU key/value table with recency tiebreak.
// A new transaction is taken only in idle, after the last result has been taken;
// each transaction runs the one-entry-per-cycle scan of the entry RAM,
// then the update state and the response state.
// Reset clears valid bits, fill count and sequencer; capacity resets to 16.
// Entry RAM and age ranks need no reset: every read is gated by a valid bit.
`default_nettype none

module lfu_cache_table #(
    parameter int CAPACITY   = lfu_pkg::CAPACITY_DEF,
    parameter int KEY_BITS   = lfu_pkg::KEY_BITS_DEF,
    parameter int VALUE_BITS = lfu_pkg::VALUE_BITS_DEF,
    parameter int COUNT_BITS = lfu_pkg::COUNT_BITS_DEF
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             in_valid,
    output logic                                  in_ready,
    input  wire logic                             operation,
    input  wire logic [lfu_pkg::PORT_KEY_W-1:0]   key,
    input  wire logic [lfu_pkg::PORT_VALUE_W-1:0] value,
    output logic                                  out_valid,
    input  wire logic                             out_ready,
    output logic                                  hit,
    output logic [lfu_pkg::PORT_VALUE_W-1:0]      read_value,
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [lfu_pkg::CAP_W-1:0]        capacity
);

    import lfu_pkg::*;

    localparam int IDX_BITS   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int FILL_BITS  = $clog2(CAPACITY + 1);
    localparam int ENTRY_BITS = KEY_BITS + VALUE_BITS + COUNT_BITS;
    localparam logic [IDX_BITS-1:0] LAST_IDX = IDX_BITS'(CAPACITY - 1);

    state_t                  state_reg, state_next;
    logic [CAP_W-1:0]        cap_reg, cap_next;
    logic [CAPACITY-1:0]     valid_reg, valid_next;
    logic [FILL_BITS-1:0]    fill_reg, fill_next;
    logic [IDX_BITS-1:0]     rank_reg [CAPACITY];
    logic [IDX_BITS-1:0]     rank_next [CAPACITY];

    logic                    op_reg, op_next;
    logic [KEY_BITS-1:0]     key_reg, key_next;
    logic [VALUE_BITS-1:0]   val_reg, val_next;

    logic [IDX_BITS-1:0]     scan_idx_reg, scan_idx_next;
    logic                    issue_reg, issue_next;
    logic                    chk_valid_reg, chk_valid_next;
    logic [IDX_BITS-1:0]     chk_idx_reg, chk_idx_next;

    logic                    found_reg, found_next;
    logic [IDX_BITS-1:0]     found_idx_reg, found_idx_next;
    logic [VALUE_BITS-1:0]   found_val_reg, found_val_next;
    logic [COUNT_BITS-1:0]   found_cnt_reg, found_cnt_next;
    logic [IDX_BITS-1:0]     found_rank_reg, found_rank_next;

    logic                    free_reg, free_next;
    logic [IDX_BITS-1:0]     free_idx_reg, free_idx_next;

    logic                    vic_reg, vic_next;
    logic [IDX_BITS-1:0]     vic_idx_reg, vic_idx_next;
    logic [COUNT_BITS-1:0]   vic_cnt_reg, vic_cnt_next;
    logic [IDX_BITS-1:0]     vic_rank_reg, vic_rank_next;

    logic                    hit_reg, hit_next;
    logic [VALUE_BITS-1:0]   rdval_reg, rdval_next;

    logic                    ram_we;
    logic [IDX_BITS-1:0]     ram_waddr;
    logic [ENTRY_BITS-1:0]   ram_wdata;
    logic [ENTRY_BITS-1:0]   ram_rdata;

    logic [KEY_BITS-1:0]     rd_key;
    logic [VALUE_BITS-1:0]   rd_val;
    logic [COUNT_BITS-1:0]   rd_cnt;
    logic                    rd_valid;
    logic [IDX_BITS-1:0]     rd_rank;

    logic [FILL_BITS-1:0]    cap_eff;
    logic                    cap_nz;
    logic                    use_free;
    logic                    evicting;
    logic                    do_touch;
    logic                    do_insert;
    logic [IDX_BITS-1:0]     slot_idx;
    logic [COUNT_BITS-1:0]   cnt_inc;

    lfu_ram #(
        .WIDTH     (ENTRY_BITS),
        .DEPTH     (CAPACITY),
        .ADDR_BITS (IDX_BITS)
    ) u_entry_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (issue_reg),
        .raddr (scan_idx_reg),
        .rdata (ram_rdata)
    );

    assign rd_key   = ram_rdata[ENTRY_BITS-1 -: KEY_BITS];
    assign rd_val   = ram_rdata[COUNT_BITS +: VALUE_BITS];
    assign rd_cnt   = ram_rdata[COUNT_BITS-1:0];
    assign rd_valid = valid_reg[chk_idx_reg];
    assign rd_rank  = rank_reg[chk_idx_reg];

    assign cap_eff  = (32'(cap_reg) > CAPACITY) ? FILL_BITS'(CAPACITY) : FILL_BITS'(cap_reg);
    assign cap_nz   = (cap_eff != '0);
    assign use_free = (fill_reg < cap_eff) && free_reg;
    assign evicting = !use_free;
    assign slot_idx = use_free ? free_idx_reg : vic_idx_reg;
    assign do_touch = found_reg && ((op_reg == OP_GET) || cap_nz);
    assign do_insert = (op_reg == OP_PUT) && cap_nz && !found_reg && (use_free || vic_reg);
    assign cnt_inc  = (found_cnt_reg == {COUNT_BITS{1'b1}}) ? found_cnt_reg
                                                             : found_cnt_reg + COUNT_BITS'(1);

    assign in_ready   = (state_reg == ST_IDLE);
    assign out_valid  = (state_reg == ST_RESP);
    assign cfg_ready  = 1'b1;
    assign hit        = hit_reg;
    assign read_value = PORT_VALUE_W'(rdval_reg);

    always_comb
    begin
        state_next      = state_reg;
        cap_next        = cap_reg;
        valid_next      = valid_reg;
        fill_next       = fill_reg;
        rank_next       = rank_reg;
        op_next         = op_reg;
        key_next        = key_reg;
        val_next        = val_reg;
        scan_idx_next   = scan_idx_reg;
        issue_next      = issue_reg;
        chk_valid_next  = 1'b0;
        chk_idx_next    = chk_idx_reg;
        found_next      = found_reg;
        found_idx_next  = found_idx_reg;
        found_val_next  = found_val_reg;
        found_cnt_next  = found_cnt_reg;
        found_rank_next = found_rank_reg;
        free_next       = free_reg;
        free_idx_next   = free_idx_reg;
        vic_next        = vic_reg;
        vic_idx_next    = vic_idx_reg;
        vic_cnt_next    = vic_cnt_reg;
        vic_rank_next   = vic_rank_reg;
        hit_next        = hit_reg;
        rdval_next      = rdval_reg;
        ram_we          = 1'b0;
        ram_waddr       = found_idx_reg;
        ram_wdata       = {key_reg, val_reg, COUNT_BITS'(1)};

        if (cfg_valid && cfg_ready)
        begin
            cap_next = capacity;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    op_next       = operation;
                    key_next      = KEY_BITS'(key);
                    val_next      = VALUE_BITS'(value);
                    scan_idx_next = '0;
                    issue_next    = 1'b1;
                    found_next    = 1'b0;
                    free_next     = 1'b0;
                    vic_next      = 1'b0;
                    state_next    = ST_SCAN;
                end
            end

            ST_SCAN:
            begin
                if (issue_reg)
                begin
                    chk_valid_next = 1'b1;
                    chk_idx_next   = scan_idx_reg;
                    if (scan_idx_reg == LAST_IDX)
                    begin
                        issue_next = 1'b0;
                    end
                    else
                    begin
                        scan_idx_next = scan_idx_reg + IDX_BITS'(1);
                    end
                end
                if (chk_valid_reg)
                begin
                    if (rd_valid && (rd_key == key_reg) && !found_reg)
                    begin
                        found_next      = 1'b1;
                        found_idx_next  = chk_idx_reg;
                        found_val_next  = rd_val;
                        found_cnt_next  = rd_cnt;
                        found_rank_next = rd_rank;
                    end
                    if (!rd_valid && !free_reg)
                    begin
                        free_next     = 1'b1;
                        free_idx_next = chk_idx_reg;
                    end
                    if (rd_valid && (!vic_reg || (rd_cnt < vic_cnt_reg) ||
                        ((rd_cnt == vic_cnt_reg) && (rd_rank > vic_rank_reg))))
                    begin
                        vic_next      = 1'b1;
                        vic_idx_next  = chk_idx_reg;
                        vic_cnt_next  = rd_cnt;
                        vic_rank_next = rd_rank;
                    end
                    if (chk_idx_reg == LAST_IDX)
                    begin
                        state_next = ST_UPDATE;
                    end
                end
            end

            ST_UPDATE:
            begin
                hit_next   = found_reg;
                rdval_next = (found_reg && (op_reg == OP_GET)) ? found_val_reg : '0;
                for (int i = 0; i < CAPACITY; i++)
                begin
                    if (do_touch)
                    begin
                        if (valid_reg[i])
                        begin
                            if (IDX_BITS'(i) == found_idx_reg)
                            begin
                                rank_next[i] = '0;
                            end
                            else if (rank_reg[i] < found_rank_reg)
                            begin
                                rank_next[i] = rank_reg[i] + IDX_BITS'(1);
                            end
                        end
                    end
                    else if (do_insert)
                    begin
                        if (IDX_BITS'(i) == slot_idx)
                        begin
                            rank_next[i] = '0;
                        end
                        else if (valid_reg[i] && !(evicting && (rank_reg[i] > vic_rank_reg)))
                        begin
                            rank_next[i] = rank_reg[i] + IDX_BITS'(1);
                        end
                    end
                end
                if (do_touch)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = found_idx_reg;
                    ram_wdata = {key_reg, (op_reg == OP_PUT) ? val_reg : found_val_reg, cnt_inc};
                end
                else if (do_insert)
                begin
                    ram_we               = 1'b1;
                    ram_waddr            = slot_idx;
                    ram_wdata            = {key_reg, val_reg, COUNT_BITS'(1)};
                    valid_next[slot_idx] = 1'b1;
                    if (!evicting)
                    begin
                        fill_next = fill_reg + FILL_BITS'(1);
                    end
                end
                state_next = ST_RESP;
            end

            ST_RESP:
            begin
                if (out_ready)
                begin
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cap_reg       <= CAP_RESET;
            valid_reg     <= '0;
            fill_reg      <= '0;
            issue_reg     <= 1'b0;
            chk_valid_reg <= 1'b0;
            scan_idx_reg  <= '0;
            found_reg     <= 1'b0;
            free_reg      <= 1'b0;
            vic_reg       <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cap_reg       <= cap_next;
            valid_reg     <= valid_next;
            fill_reg      <= fill_next;
            issue_reg     <= issue_next;
            chk_valid_reg <= chk_valid_next;
            scan_idx_reg  <= scan_idx_next;
            found_reg     <= found_next;
            free_reg      <= free_next;
            vic_reg       <= vic_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rank_reg       <= rank_next;
        op_reg         <= op_next;
        key_reg        <= key_next;
        val_reg        <= val_next;
        chk_idx_reg    <= chk_idx_next;
        found_idx_reg  <= found_idx_next;
        found_val_reg  <= found_val_next;
        found_cnt_reg  <= found_cnt_next;
        found_rank_reg <= found_rank_next;
        free_idx_reg   <= free_idx_next;
        vic_idx_reg    <= vic_idx_next;
        vic_cnt_reg    <= vic_cnt_next;
        vic_rank_reg   <= vic_rank_next;
        hit_reg        <= hit_next;
        rdval_reg      <= rdval_next;
    end

    a_fill_tracks_valid: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(valid_reg) == 32'(fill_reg))
        else $error("fill count differs from number of valid entries");

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(fill_reg) <= CAPACITY)
        else $error("fill count above capacity");

    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("input accepted while result pending");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (!in_ready && !out_valid))
        else $error("sequencer did not start scan after transaction");

endmodule

`default_nettype wire
